// File: rtl/core/hce_pkg.sv
// Shared types, constants and helpers for the Hill cipher encryptor.
`timescale 1ns / 1ps
package hce_pkg;

  localparam int MAX_KEY    = 10;
  localparam int KEY_DEPTH  = MAX_KEY * MAX_KEY;
  localparam int KEY_AW     = $clog2(KEY_DEPTH);
  localparam int IDX_W      = 4;
  localparam int LET_W      = 5;
  localparam int PROD_W     = 2 * LET_W;
  localparam int ALPHABET   = 26;
  // floor(x * RECIP_26 / 2^RECIP_SH) == floor(x / 26) for x < 1024
  localparam int RECIP_26   = 2521;
  localparam int RECIP_SH   = 16;
  localparam logic [LET_W-1:0] PAD_LETTER = 5'd23;

  typedef enum logic {
    REQ_KEY    = 1'b0,
    REQ_LETTER = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic             req_type;
    logic [3:0]       key_row;
    logic [3:0]       key_col;
    logic [LET_W-1:0] key_value;
    logic [LET_W-1:0] letter;
    logic             message_end;
  } in_item_t;

  typedef struct packed {
    logic [LET_W-1:0] cipher_letter;
    logic             last_of_block;
    logic             last_of_message;
  } out_item_t;

  typedef enum logic {
    CMD_KEY    = 1'b0,
    CMD_LETTER = 1'b1
  } cmd_kind_t;

  // addr: key store address for CMD_KEY, block slot for CMD_LETTER
  typedef struct packed {
    cmd_kind_t         kind;
    logic [KEY_AW-1:0] addr;
    logic [LET_W-1:0]  data;
    logic              emit;
    logic              msg_end;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_ROW_WAIT = 2'd1,
    ST_ISSUE    = 2'd2
  } back_state_t;

  typedef struct packed {
    logic first;
    logic last_row;
    logic last_blk;
    logic msg_end;
  } mac_tag_t;

  // x mod 26 for x below 1024, by reciprocal multiply
  function automatic logic [LET_W-1:0] mod26(input logic [PROD_W-1:0] x);
    logic [RECIP_SH+PROD_W-1:0] p;
    logic [PROD_W-1:0]          q;
    logic [PROD_W-1:0]          r;
    p = {{RECIP_SH{1'b0}}, x} * (RECIP_SH + PROD_W)'(RECIP_26);
    q = PROD_W'(p >> RECIP_SH);
    r = x - PROD_W'(q * PROD_W'(ALPHABET));
    return r[LET_W-1:0];
  endfunction

endpackage

// File: rtl/core/hce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/hce_front.sv
// Front end: accepts input beats, tracks block fill, emits commands.
`timescale 1ns / 1ps
module hce_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hce_pkg::in_item_t in_data,
  input  logic [3:0]        eff_size,
  input  logic              q_full,
  output logic              push,
  output hce_pkg::cmd_t     push_cmd
);
  import hce_pkg::*;

  logic [IDX_W-1:0] fill_r;
  logic [IDX_W-1:0] fill_nxt;
  logic             accept;
  logic [IDX_W:0]   fill_inc;
  logic             key_ok;
  logic [7:0]       key_addr;
  logic             emit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign fill_inc = {1'b0, fill_r} + (IDX_W+1)'(1);
  assign key_ok   = (in_data.key_row < 4'(MAX_KEY)) && (in_data.key_col < 4'(MAX_KEY));
  assign key_addr = {4'b0, in_data.key_row} * 8'(MAX_KEY) + {4'b0, in_data.key_col};
  assign emit     = (fill_inc >= {1'b0, eff_size}) || in_data.message_end;

  always_comb begin
    push_cmd = '0;
    push     = 1'b0;
    fill_nxt = fill_r;
    if (in_data.req_type == REQ_KEY) begin
      push_cmd.kind = CMD_KEY;
      push_cmd.addr = key_addr[KEY_AW-1:0];
      push_cmd.data = in_data.key_value;
      push          = accept && key_ok;
    end else begin
      push_cmd.kind    = CMD_LETTER;
      push_cmd.addr    = KEY_AW'(fill_r);
      push_cmd.data    = in_data.letter;
      push_cmd.emit    = emit;
      push_cmd.msg_end = in_data.message_end;
      push             = accept;
      if (accept) begin
        fill_nxt = emit ? '0 : fill_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// File: rtl/core/hce_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module hce_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hce_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output hce_pkg::cmd_t     head,
  output hce_pkg::q_stat_t  stat
);
  import hce_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/core/hce_back.sv
// Back end: key store, block buffer and serial multiply-accumulate.
`timescale 1ns / 1ps
module hce_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         eff_size,
  input  hce_pkg::cmd_t      head,
  input  hce_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output hce_pkg::out_item_t out_data
);
  import hce_pkg::*;

  back_state_t       st_r;
  back_state_t       st_nxt;
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  k_r;
  logic [IDX_W-1:0]  pad_r;
  logic              end_r;
  logic [LET_W-1:0]  buf_r [MAX_KEY];

  logic              s1_vld_r;
  logic [LET_W-1:0]  s1_b_r;
  mac_tag_t          s1_tag_r;
  logic              s2_vld_r;
  logic [PROD_W-1:0] prod_r;
  mac_tag_t          s2_tag_r;
  logic [LET_W-1:0]  acc_r;
  logic [LET_W-1:0]  acc_nxt;
  logic [PROD_W-1:0] acc_sum;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              ram_we;
  logic              buf_we;
  logic              start_blk;
  logic              issue;
  logic              row_end;
  logic              pipe_empty;
  logic [IDX_W-1:0]  n_m1;
  logic [7:0]        rd_addr_w;
  logic [LET_W-1:0]  key_rd;
  logic [LET_W-1:0]  blk_val;

  assign n_m1       = eff_size - 4'd1;
  assign row_end    = (k_r == n_m1);
  assign pipe_empty = !s1_vld_r && !s2_vld_r;
  assign rd_addr_w  = {4'b0, j_r} * 8'(MAX_KEY) + {4'b0, k_r};
  assign blk_val    = (k_r >= pad_r) ? PAD_LETTER : buf_r[k_r];

  hce_ram #(
    .WIDTH (LET_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.addr),
    .wdata (head.data),
    .raddr (rd_addr_w[KEY_AW-1:0]),
    .rdata (key_rd)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty && head.kind == CMD_LETTER && head.emit) begin
          st_nxt = ST_ROW_WAIT;
        end
      end
      ST_ROW_WAIT: begin
        if (pipe_empty) begin
          if (j_r == eff_size) begin
            st_nxt = ST_IDLE;
          end else if (!out_valid_r) begin
            st_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (row_end) begin
          st_nxt = ST_ROW_WAIT;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    buf_we    = 1'b0;
    start_blk = 1'b0;
    issue     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        pop       = !q_stat.empty;
        ram_we    = pop && (head.kind == CMD_KEY);
        buf_we    = pop && (head.kind == CMD_LETTER) &&
                    (head.addr < KEY_AW'(MAX_KEY));
        start_blk = pop && (head.kind == CMD_LETTER) && head.emit;
      end
      ST_ROW_WAIT: begin
      end
      ST_ISSUE: begin
        issue = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign acc_sum = (s2_tag_r.first ? PROD_W'(0) : PROD_W'(acc_r)) + prod_r;
  assign acc_nxt = mod26(acc_sum);

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[head.addr[IDX_W-1:0]] <= head.data;
    end
    if (start_blk) begin
      pad_r <= head.addr[IDX_W-1:0] + IDX_W'(1);
      end_r <= head.msg_end;
    end
    s1_b_r            <= blk_val;
    s1_tag_r.first    <= (k_r == '0);
    s1_tag_r.last_row <= row_end;
    s1_tag_r.last_blk <= (j_r == n_m1);
    s1_tag_r.msg_end  <= end_r;
    prod_r            <= PROD_W'(key_rd) * PROD_W'(s1_b_r);
    s2_tag_r          <= s1_tag_r;
    if (s2_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (s2_vld_r && s2_tag_r.last_row) begin
      out_r.cipher_letter   <= acc_nxt;
      out_r.last_of_block   <= s2_tag_r.last_blk;
      out_r.last_of_message <= s2_tag_r.last_blk && s2_tag_r.msg_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      j_r         <= '0;
      k_r         <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      if (start_blk) begin
        j_r <= '0;
        k_r <= '0;
      end else if (issue) begin
        if (row_end) begin
          k_r <= '0;
          j_r <= j_r + IDX_W'(1);
        end else begin
          k_r <= k_r + IDX_W'(1);
        end
      end
      if (s2_vld_r && s2_tag_r.last_row) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/hill_cipher_encrypt.sv
// Top level of the Hill cipher encryptor: config register, front, queue, back.
`timescale 1ns / 1ps
// Hill cipher encryptor over letters 0..25. Input beats either write one key
// entry (row, col, value) or deliver one plaintext letter; once key_size
// letters are in (or message_end arrives, padding the rest with 'X' = 23) the
// block emits key_size cipher letters, row j being sum_k key[j][k]*p[k] mod 26.
// The input takes a beat whenever the command queue is not full, and the back
// end pops key writes and letters while it is idle. A block starts once its
// closing letter leaves the queue, and its rows are computed by the single
// multiply-accumulate unit and the one read port of the key RAM, one key entry
// per cycle within a row; between rows the back end waits for the pipeline to
// drain and for the previous cipher letter to be taken. A two-beat command
// queue lets the input take up to two beats while a block is being computed.
// The user must write key_size through cfg_* only while the block is idle; the
// block itself does not enforce this. 0 acts as 1 and values above 10 act as
// 10. Key writes outside 10x10 are dropped.
module hill_cipher_encrypt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hce_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hce_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  import hce_pkg::*;

  logic [3:0] key_size_r;
  logic [3:0] eff_size;
  logic       push;
  cmd_t       push_cmd;
  cmd_t       head;
  q_stat_t    q_stat;
  logic       pop;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      key_size_r <= cfg_data;
    end
  end

  // clamp to 1..MAX_KEY
  always_comb begin
    if (key_size_r == 4'd0) begin
      eff_size = 4'd1;
    end else if (key_size_r > 4'(MAX_KEY)) begin
      eff_size = 4'(MAX_KEY);
    end else begin
      eff_size = key_size_r;
    end
  end

  hce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .eff_size (eff_size),
    .q_full   (q_stat.full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  hce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_size  (eff_size),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // cipher letters are always reduced
  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cipher_letter < 5'(ALPHABET))
    else $error("cipher letter out of range");

  // message end only on the closing letter of a block
  a_end_on_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_message |-> out_data.last_of_block)
    else $error("last_of_message without last_of_block");

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
